### rtl/cia402_dsc_pkg.sv
// cia402_dsc_pkg: drive state codes, controlword values, statusword masks and values
// and the item/result types of the CiA402 drive state controller; no dependencies
`timescale 1ns / 1ps

package cia402_dsc_pkg;

    localparam logic [2:0] ST_NOT_READY      = 3'd0;
    localparam logic [2:0] ST_SW_ON_DISABLED = 3'd1;
    localparam logic [2:0] ST_READY          = 3'd2;
    localparam logic [2:0] ST_SWITCHED_ON    = 3'd3;
    localparam logic [2:0] ST_OP_ENABLED     = 3'd4;
    localparam logic [2:0] ST_FAULT          = 3'd5;

    localparam logic [15:0] CW_NONE        = 16'h0000;
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE      = 16'h000F;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

    localparam logic [15:0] SW_MASK_SHORT  = 16'h004F;
    localparam logic [15:0] SW_MASK_LONG   = 16'h006F;
    localparam logic [15:0] SW_VAL_FAULT   = 16'h0008;
    localparam logic [15:0] SW_VAL_OP_EN   = 16'h0027;
    localparam logic [15:0] SW_VAL_SW_ON   = 16'h0023;
    localparam logic [15:0] SW_VAL_READY   = 16'h0021;
    localparam logic [15:0] SW_VAL_DISABLE = 16'h0040;

    typedef struct packed {
        logic [15:0]        status_word;
        logic signed [31:0] actual_position;
        logic [15:0]        drive_error_code;
        logic signed [15:0] actual_torque;
        logic signed [31:0] target_pos;
        logic               enable_request;
        logic               fault_reset_pulse;
        logic               zero_cal_pulse;
    } item_t;

    typedef struct packed {
        logic [15:0]        control_word;
        logic signed [31:0] target_out;
        logic               mode_write;
        logic [31:0]        velocity_limit_out;
        logic [2:0]         drive_state;
        logic               op_enabled;
        logic [15:0]        error_code_out;
        logic signed [31:0] position_counts;
        logic signed [15:0] actual_torque;
    } result_t;

endpackage

### rtl/cia402_drive_state_controller.sv
// cia402_drive_state_controller: top level with input register, zero offset state
// and result register; depends on cia402_dsc_pkg and cia402_dsc_calc
`timescale 1ns / 1ps

// usage
// one process-image item enters on the in_valid/in_ready channel; each transfer
// yields exactly one result on the out_valid/out_ready channel, in order
// out_valid rises once the item has passed the input register and then the result
// register; throughput: one item per cycle while the receiver does not stall, set by
// the single pass of decode logic, one 32-bit add and one 32-bit subtract between the two registers
// when the receiver stalls the result register holds; the input register still
// takes one more item, and in_ready drops only when both stages are full
// the velocity limit is written through cfg_wr_en/cfg_wr_data, by the user only
// while idle (the block itself does not enforce this), and is copied into every result
// reset clears both valid flags, the zero offset and the velocity register;
// there is no clearing pass, the block is ready in the first cycle after reset
// zero_cal_pulse latches the raw position before the outputs of that item are
// formed, so its position_counts reads zero

module cia402_drive_state_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        status_word,
    input  logic signed [31:0] actual_position,
    input  logic [15:0]        drive_error_code,
    input  logic signed [15:0] actual_torque,
    input  logic signed [31:0] target_pos,
    input  logic               enable_request,
    input  logic               fault_reset_pulse,
    input  logic               zero_cal_pulse,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        control_word,
    output logic signed [31:0] target_out,
    output logic               mode_write,
    output logic [31:0]        velocity_limit_out,
    output logic [2:0]         drive_state,
    output logic               op_enabled,
    output logic [15:0]        error_code_out,
    output logic signed [31:0] position_counts,
    output logic signed [15:0] torque_out,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);
    import cia402_dsc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    item_t       item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_calc;
    logic [31:0] zero_offset_reg;
    logic [31:0] zero_offset_calc;
    logic [31:0] vel_limit_reg;
    logic        out_free;
    logic        advance;
    logic        in_xfer;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    cia402_dsc_calc u_calc (
        .item             (item_reg),
        .zero_offset      (zero_offset_reg),
        .vel_limit        (vel_limit_reg),
        .result           (result_calc),
        .zero_offset_next (zero_offset_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            zero_offset_reg <= 32'h0000_0000;
            vel_limit_reg   <= 32'h0000_0000;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                zero_offset_reg <= zero_offset_calc;
            if (cfg_wr_en)
                vel_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.status_word       <= status_word;
            item_reg.actual_position   <= actual_position;
            item_reg.drive_error_code  <= drive_error_code;
            item_reg.actual_torque     <= actual_torque;
            item_reg.target_pos        <= target_pos;
            item_reg.enable_request    <= enable_request;
            item_reg.fault_reset_pulse <= fault_reset_pulse;
            item_reg.zero_cal_pulse    <= zero_cal_pulse;
        end
        if (advance)
            result_reg <= result_calc;
    end

    assign out_valid          = out_valid_reg;
    assign control_word       = result_reg.control_word;
    assign target_out         = result_reg.target_out;
    assign mode_write         = result_reg.mode_write;
    assign velocity_limit_out = result_reg.velocity_limit_out;
    assign drive_state        = result_reg.drive_state;
    assign op_enabled         = result_reg.op_enabled;
    assign error_code_out     = result_reg.error_code_out;
    assign position_counts    = result_reg.position_counts;
    assign torque_out         = result_reg.actual_torque;

    // zero calibration reaches the offset register when its item leaves the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.zero_cal_pulse |=> zero_offset_reg == $past(item_reg.actual_position))
        else $error("zero offset not latched from calibrating item");

    // offset only moves with an item that asked for calibration
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && item_reg.zero_cal_pulse) |=> $stable(zero_offset_reg))
        else $error("zero offset changed without calibration");

    // mode write only on the switched-on enable step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.mode_write |->
            result_reg.drive_state == ST_SWITCHED_ON && result_reg.control_word == CW_ENABLE)
        else $error("mode write outside switched-on enable");

    // error code and the fault reset controlword only reported in fault
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.drive_state != ST_FAULT |->
            result_reg.error_code_out == 16'h0000 && result_reg.control_word != CW_FAULT_RESET)
        else $error("fault outputs outside fault state");

    // a full pipeline with a stalled receiver must not take another item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken with both stages full");

endmodule

### rtl/cia402_dsc_calc.sv
// cia402_dsc_calc: combinational state decode, controlword build and position math
// for one registered item; depends on cia402_dsc_pkg
`timescale 1ns / 1ps

module cia402_dsc_calc (
    input  cia402_dsc_pkg::item_t   item,
    input  logic [31:0]             zero_offset,
    input  logic [31:0]             vel_limit,
    output cia402_dsc_pkg::result_t result,
    output logic [31:0]             zero_offset_next
);
    import cia402_dsc_pkg::*;

    logic [2:0]  state;
    logic [15:0] cw;
    logic        mode;
    logic [31:0] offset_eff;

    always_comb
    begin
        if ((item.status_word & SW_MASK_SHORT) == SW_VAL_FAULT)
            state = ST_FAULT;
        else if ((item.status_word & SW_MASK_LONG) == SW_VAL_OP_EN)
            state = ST_OP_ENABLED;
        else if ((item.status_word & SW_MASK_LONG) == SW_VAL_SW_ON)
            state = ST_SWITCHED_ON;
        else if ((item.status_word & SW_MASK_LONG) == SW_VAL_READY)
            state = ST_READY;
        else if ((item.status_word & SW_MASK_SHORT) == SW_VAL_DISABLE)
            state = ST_SW_ON_DISABLED;
        else
            state = ST_NOT_READY;
    end

    // latch takes effect before the outputs of the same item
    assign offset_eff = item.zero_cal_pulse ? item.actual_position : zero_offset;
    assign zero_offset_next = offset_eff;

    always_comb
    begin
        cw   = CW_NONE;
        mode = 1'b0;
        if (item.fault_reset_pulse)
        begin
            if (state == ST_FAULT)
                cw = CW_FAULT_RESET;
        end
        else if (item.enable_request)
        begin
            case (state)
                ST_FAULT:          cw = CW_NONE;
                ST_SW_ON_DISABLED: cw = CW_SHUTDOWN;
                ST_READY:          cw = CW_SWITCH_ON;
                ST_SWITCHED_ON:
                begin
                    cw   = CW_ENABLE;
                    mode = 1'b1;
                end
                ST_OP_ENABLED:     cw = CW_ENABLE;
                default:           cw = CW_SHUTDOWN;
            endcase
        end
        else
        begin
            if (state == ST_OP_ENABLED || state == ST_SWITCHED_ON || state == ST_READY)
                cw = CW_SHUTDOWN;
        end
    end

    always_comb
    begin
        result.control_word       = cw;
        result.target_out         = (state == ST_OP_ENABLED)
                                    ? item.target_pos + $signed(offset_eff)
                                    : item.actual_position;
        result.mode_write         = mode;
        result.velocity_limit_out = vel_limit;
        result.drive_state        = state;
        result.op_enabled         = (state == ST_OP_ENABLED);
        result.error_code_out     = (state == ST_FAULT) ? item.drive_error_code : 16'h0000;
        result.position_counts    = item.actual_position - $signed(offset_eff);
        result.actual_torque      = item.actual_torque;
    end

endmodule

### verif/cia402_dsc_checker.sv
// cia402_dsc_checker: watches the item, result and register ports of the drive state
// controller, predicts each result and compares it field by field; depends on cia402_dsc_pkg
`timescale 1ns / 1ps

module cia402_dsc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  cia402_dsc_pkg::item_t in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [15:0]           control_word,
    input  logic signed [31:0]    target_out,
    input  logic                  mode_write,
    input  logic [31:0]           velocity_limit_out,
    input  logic [2:0]            drive_state,
    input  logic                  op_enabled,
    input  logic [15:0]           error_code_out,
    input  logic signed [31:0]    position_counts,
    input  logic signed [15:0]    torque_out,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    output int                    fail_count,
    output int                    pending_results
);
    import cia402_dsc_pkg::*;

    logic [31:0] zero_offset_q;
    logic [31:0] velocity_limit_q;
    result_t     expected_results[$];

    function automatic logic [2:0] decode_drive_state(input logic [15:0] sw);
        if ((sw & SW_MASK_SHORT) == SW_VAL_FAULT)
            return ST_FAULT;
        if ((sw & SW_MASK_LONG) == SW_VAL_OP_EN)
            return ST_OP_ENABLED;
        if ((sw & SW_MASK_LONG) == SW_VAL_SW_ON)
            return ST_SWITCHED_ON;
        if ((sw & SW_MASK_LONG) == SW_VAL_READY)
            return ST_READY;
        if ((sw & SW_MASK_SHORT) == SW_VAL_DISABLE)
            return ST_SW_ON_DISABLED;
        return ST_NOT_READY;
    endfunction

    // offset is the value after any zero latch of this item
    function automatic result_t predict_drive_response(input item_t it,
                                                       input logic [31:0] offset,
                                                       input logic [31:0] vel_limit);
        result_t    r;
        logic [2:0] st;
        r  = '0;
        st = decode_drive_state(it.status_word);
        r.control_word = CW_NONE;
        if (it.fault_reset_pulse)
        begin
            if (st == ST_FAULT)
                r.control_word = CW_FAULT_RESET;
        end
        else if (it.enable_request)
        begin
            case (st)
                ST_FAULT:          r.control_word = CW_NONE;
                ST_SW_ON_DISABLED: r.control_word = CW_SHUTDOWN;
                ST_READY:          r.control_word = CW_SWITCH_ON;
                ST_SWITCHED_ON:
                begin
                    r.control_word = CW_ENABLE;
                    r.mode_write   = 1'b1;
                end
                ST_OP_ENABLED:     r.control_word = CW_ENABLE;
                default:           r.control_word = CW_SHUTDOWN;
            endcase
        end
        else if (st == ST_OP_ENABLED || st == ST_SWITCHED_ON || st == ST_READY)
        begin
            r.control_word = CW_SHUTDOWN;
        end
        if (st == ST_OP_ENABLED)
            r.target_out = it.target_pos + offset;
        else
            r.target_out = it.actual_position;
        r.velocity_limit_out = vel_limit;
        r.drive_state        = st;
        r.op_enabled         = (st == ST_OP_ENABLED);
        r.error_code_out     = (st == ST_FAULT) ? it.drive_error_code : 16'h0000;
        r.position_counts    = it.actual_position - offset;
        r.actual_torque      = it.actual_torque;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s: expected %h, actual %h", name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t oldest;
        if (!rst_n)
        begin
            zero_offset_q    = '0;
            velocity_limit_q = '0;
            expected_results.delete();
            fail_count       = 0;
            pending_results  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                velocity_limit_q = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("control_word", 32'(oldest.control_word),
                                32'(control_word));
                    check_field("target_out", oldest.target_out, target_out);
                    check_field("mode_write", 32'(oldest.mode_write), 32'(mode_write));
                    check_field("velocity_limit_out", oldest.velocity_limit_out,
                                velocity_limit_out);
                    check_field("drive_state", 32'(oldest.drive_state), 32'(drive_state));
                    check_field("op_enabled", 32'(oldest.op_enabled), 32'(op_enabled));
                    check_field("error_code_out", 32'(oldest.error_code_out),
                                32'(error_code_out));
                    check_field("position_counts", oldest.position_counts, position_counts);
                    check_field("torque_out", 32'(oldest.actual_torque), 32'(torque_out));
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_item.zero_cal_pulse)
                    zero_offset_q = in_item.actual_position;
                expected_results.push_back(
                    predict_drive_response(in_item, zero_offset_q, velocity_limit_q));
            end
            pending_results = expected_results.size();
        end
    end

endmodule

### verif/cia402_drive_state_controller_tb.sv
// cia402_drive_state_controller_tb: drives process-image items and velocity limit writes
// into the drive state controller under several idle patterns and reports the verdict;
// depends on cia402_dsc_pkg, cia402_dsc_checker and the controller itself
`timescale 1ns / 1ps

module cia402_drive_state_controller_tb;
    import cia402_dsc_pkg::*;

    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 254;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        out_ready   = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    item_t       drv_item    = '0;

    logic               in_ready;
    logic               out_valid;
    logic [15:0]        control_word;
    logic signed [31:0] target_out;
    logic               mode_write;
    logic [31:0]        velocity_limit_out;
    logic [2:0]         drive_state;
    logic               op_enabled;
    logic [15:0]        error_code_out;
    logic signed [31:0] position_counts;
    logic signed [15:0] torque_out;

    int fail_count;
    int pending_results;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int          phase_send_idle[RANDOM_PHASES]  = '{0, 82, 0, 9, 0, 82};
    int          phase_recv_stall[RANDOM_PHASES] = '{0, 0, 82, 9, 0, 0};
    logic [31:0] phase_vel_limit[RANDOM_PHASES];

    always #5 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    cia402_drive_state_controller dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .status_word        (drv_item.status_word),
        .actual_position    (drv_item.actual_position),
        .drive_error_code   (drv_item.drive_error_code),
        .actual_torque      (drv_item.actual_torque),
        .target_pos         (drv_item.target_pos),
        .enable_request     (drv_item.enable_request),
        .fault_reset_pulse  (drv_item.fault_reset_pulse),
        .zero_cal_pulse     (drv_item.zero_cal_pulse),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .control_word       (control_word),
        .target_out         (target_out),
        .mode_write         (mode_write),
        .velocity_limit_out (velocity_limit_out),
        .drive_state        (drive_state),
        .op_enabled         (op_enabled),
        .error_code_out     (error_code_out),
        .position_counts    (position_counts),
        .torque_out         (torque_out),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data)
    );

    cia402_dsc_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_item            (drv_item),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .control_word       (control_word),
        .target_out         (target_out),
        .mode_write         (mode_write),
        .velocity_limit_out (velocity_limit_out),
        .drive_state        (drive_state),
        .op_enabled         (op_enabled),
        .error_code_out     (error_code_out),
        .position_counts    (position_counts),
        .torque_out         (torque_out),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .fail_count         (fail_count),
        .pending_results    (pending_results)
    );

    function automatic item_t make_item(input logic [15:0] sw, input logic [31:0] pos,
                                        input logic [15:0] err, input logic [15:0] trq,
                                        input logic [31:0] tgt, input logic en,
                                        input logic frst, input logic zcal);
        item_t it;
        it.status_word       = sw;
        it.actual_position   = pos;
        it.drive_error_code  = err;
        it.actual_torque     = trq;
        it.target_pos        = tgt;
        it.enable_request    = en;
        it.fault_reset_pulse = frst;
        it.zero_cal_pulse    = zcal;
        return it;
    endfunction

    function automatic logic [31:0] pick_count_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly statuswords of a known state with random don't-care bits
    function automatic item_t random_process_image();
        logic [15:0] base;
        logic [15:0] care;
        logic [15:0] sw;
        case ($urandom_range(9))
            0, 1:    begin base = SW_VAL_FAULT;   care = SW_MASK_SHORT; end
            2, 3:    begin base = SW_VAL_OP_EN;   care = SW_MASK_LONG;  end
            4:       begin base = SW_VAL_SW_ON;   care = SW_MASK_LONG;  end
            5:       begin base = SW_VAL_READY;   care = SW_MASK_LONG;  end
            6:       begin base = SW_VAL_DISABLE; care = SW_MASK_SHORT; end
            7:       begin base = 16'h0000;       care = SW_MASK_LONG;  end
            default: begin base = 16'h0000;       care = 16'h0000;      end
        endcase
        sw = (base & care) | (16'($urandom) & ~care);
        return make_item(sw, pick_count_value(), 16'($urandom), 16'($urandom),
                         pick_count_value(), $urandom_range(99) < 75,
                         $urandom_range(99) < 10, $urandom_range(99) < 8);
    endfunction

    task automatic send_process_image(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv_item <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_velocity_limit(input logic [31:0] value);
        drain_results();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        phase_vel_limit = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0000,
                            32'h0000_0001, $urandom};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_velocity_limit($urandom);

        // state decode and controlword sequencing, enable requested
        send_process_image(make_item(16'h0000, 32'h0, 16'h0, 16'h0, 32'h0,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0040, 32'h7FFF_FFFF, 16'h0, 16'h7FFF, 32'h0,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0060, 32'h8000_0000, 16'h0, 16'h8000, 32'h0,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0021, 32'd123, 16'h0, 16'h0001, 32'h5,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0023, 32'd456, 16'h0, 16'hFFFF, 32'h5,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0027, 32'd1000, 16'h0, 16'h0, 32'h5,
                                     1'b1, 1'b0, 1'b0));
        // zero latch while enabled, target sum wraps
        send_process_image(make_item(16'h0027, 32'h7FFF_FFFF, 16'h0, 16'h0, 32'h1,
                                     1'b1, 1'b0, 1'b1));
        send_process_image(make_item(16'hFFA7, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
                                     32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
        // fault handling
        send_process_image(make_item(16'h0008, 32'd77, 16'hFFFF, 16'h0, 32'h0,
                                     1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0028, 32'd78, 16'h1234, 16'h0, 32'h0,
                                     1'b1, 1'b1, 1'b0));
        send_process_image(make_item(16'hFFB8, 32'd79, 16'h8001, 16'h0, 32'h0,
                                     1'b0, 1'b1, 1'b0));
        // fault reset outside fault
        send_process_image(make_item(16'h0027, 32'd80, 16'h0, 16'h0, 32'h9,
                                     1'b1, 1'b1, 1'b0));
        send_process_image(make_item(16'h0040, 32'd81, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b1, 1'b0));
        send_process_image(make_item(16'h0023, 32'd82, 16'h0, 16'h0, 32'h0,
                                     1'b1, 1'b1, 1'b0));
        // disable requested in every state
        send_process_image(make_item(16'h0027, 32'd90, 16'h0, 16'h0, 32'h3,
                                     1'b0, 1'b0, 1'b0));
        send_process_image(make_item(16'h0023, 32'd91, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b0));
        send_process_image(make_item(16'h0021, 32'd92, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b0));
        send_process_image(make_item(16'h0040, 32'd93, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b0));
        send_process_image(make_item(16'h0008, 32'd94, 16'h0001, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b0));
        send_process_image(make_item(16'h0000, 32'd95, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b0));
        // zero latch at the extremes
        send_process_image(make_item(16'h0040, 32'h8000_0000, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b1));
        send_process_image(make_item(16'h0027, 32'h7FFF_FFFF, 16'h0, 16'h0,
                                     32'h8000_0000, 1'b1, 1'b0, 1'b0));
        send_process_image(make_item(16'h0000, 32'h0, 16'h0, 16'h0, 32'h0,
                                     1'b0, 1'b0, 1'b1));
        send_process_image(make_item(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        send_process_image(make_item(16'h0027, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF,
                                     1'b1, 1'b0, 1'b0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_velocity_limit(phase_vel_limit[ph]);
            send_idle_pct  = phase_send_idle[ph];
            recv_stall_pct = phase_recv_stall[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_process_image(random_process_image());
            end
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
